@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker module of the moving median block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define MMF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("moving median check failed");

// Next-cycle implication, switched off while reset is asserted.
`define MMF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("moving median check failed");

`endif

@@ hw/rtl/mmf_pkg.sv @@
// Package for the six-channel moving median filter: sizes, request codes and
// the link structure passed between neighbouring sorting cells. No dependencies.
package mmf_pkg;

	localparam int WINDOW      = 9;
	localparam int SAMPLE_BITS = 16;
	localparam int TAG_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int MID         = WINDOW / 2;

	// Request function codes.
	localparam logic FUNC_PUSH    = 1'b0;
	localparam logic FUNC_PRELOAD = 1'b1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [TAG_W-1:0]              tag_t;

	localparam tag_t LAST_TAG = tag_t'(WINDOW - 1);

	// Handed from a cell to the cell above it in sorted order.
	typedef struct packed {
		sample_t c;      // value this cell holds once the removed entry is taken out
		tag_t    c_tag;  // ring slot of that value
		logic    g;      // that value is greater than the incoming sample, or this is the last cell
		logic    rm_le;  // the removed entry sits at or below this cell
	} link_t;

endpackage

@@ hw/rtl/mmf_cell.sv @@
// One cell of a sorted window chain: holds one sample and its ring slot.
// Depends on mmf_pkg.
module mmf_cell import mmf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  logic    preload,
	input  tag_t    tag_init,
	input  logic    is_last,
	input  tag_t    oldest,
	input  sample_t sample,
	input  link_t   lo_in,
	input  sample_t up_val,
	input  tag_t    up_tag,
	output sample_t val,
	output tag_t    tag,
	output link_t   up_out
);

	sample_t val_q;
	tag_t    tag_q;
	sample_t c;
	tag_t    c_tag;
	logic    rm_le;
	logic    g;
	sample_t nxt_val;
	tag_t    nxt_tag;

	// Take the oldest entry out: cells at and above it shift down by one.
	always_comb begin
		rm_le = lo_in.rm_le | (tag_q == oldest);
		c     = rm_le ? up_val : val_q;
		c_tag = rm_le ? up_tag : tag_q;
		g     = is_last | (c > sample);
	end

	// Insert the new sample: larger entries move up, the sample lands in the gap.
	always_comb begin
		if (lo_in.g) begin
			nxt_val = lo_in.c;
			nxt_tag = lo_in.c_tag;
		end else if (g) begin
			nxt_val = sample;
			nxt_tag = oldest;
		end else begin
			nxt_val = c;
			nxt_tag = c_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			tag_q <= tag_init;
		end else if (preload) begin
			val_q <= sample;
			tag_q <= tag_init;
		end else if (push) begin
			val_q <= nxt_val;
			tag_q <= nxt_tag;
		end
	end

	assign val    = val_q;
	assign tag    = tag_q;
	assign up_out = '{c: c, c_tag: c_tag, g: g, rm_le: rm_le};

endmodule

@@ hw/rtl/mmf_chain.sv @@
// One channel: a row of sorting cells kept in ascending order, and the median
// taken from the middle of the row. Depends on mmf_pkg and mmf_cell.
module mmf_chain import mmf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  logic    preload,
	input  tag_t    oldest,
	input  sample_t sample,
	output sample_t median
);

	sample_t val  [WINDOW];
	tag_t    tag  [WINDOW];
	link_t   link [WINDOW];

	// The row of cells, lowest value at index zero.
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		link_t   lo_in;
		sample_t up_val;
		tag_t    up_tag;

		if (i == 0) begin : g_lo_first
			assign lo_in = '0;
		end else begin : g_lo_mid
			assign lo_in = link[i-1];
		end

		if (i == WINDOW - 1) begin : g_up_last
			assign up_val = '0;
			assign up_tag = '0;
		end else begin : g_up_mid
			assign up_val = val[i+1];
			assign up_tag = tag[i+1];
		end

		mmf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.push     (push),
			.preload  (preload),
			.tag_init (tag_t'(i)),
			.is_last  (i == WINDOW - 1),
			.oldest   (oldest),
			.sample   (sample),
			.lo_in    (lo_in),
			.up_val   (up_val),
			.up_tag   (up_tag),
			.val      (val[i]),
			.tag      (tag[i]),
			.up_out   (link[i])
		);
	end

	// Median: the middle cell, or the floor average of the two middle cells.
	if (WINDOW % 2 == 1) begin : g_odd
		assign median = val[MID];
	end else begin : g_even
		logic signed [SAMPLE_BITS:0] sum;
		assign sum    = {val[MID-1][SAMPLE_BITS-1], val[MID-1]}
			+ {val[MID][SAMPLE_BITS-1], val[MID]};
		assign median = sum[SAMPLE_BITS:1];
	end

endmodule

@@ hw/rtl/six_channel_moving_median.sv @@
// Results: the sorted cell rows update when a push request is accepted, and the
// medians are registered once the output register is free or emptying.
// Throughput: one request per cycle while results are taken.
// A preload request gives no result.
// Reset (arst_n low): every window clears to zero, the oldest slot to zero.
// Depends on mmf_pkg and mmf_chain.
module six_channel_moving_median import mmf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    func,
	input  sample_t accel_x,
	input  sample_t accel_y,
	input  sample_t accel_z,
	input  sample_t gyro_x,
	input  sample_t gyro_y,
	input  sample_t gyro_z,
	output logic    out_valid,
	input  logic    out_ready,
	output sample_t med_accel_x,
	output sample_t med_accel_y,
	output sample_t med_accel_z,
	output sample_t med_gyro_x,
	output sample_t med_gyro_y,
	output sample_t med_gyro_z
);

	localparam int CHANNELS = 6;

	logic    pend_q;
	logic    out_valid_q;
	tag_t    oldest_q;
	logic    accept;
	logic    push;
	logic    preload;
	logic    load;
	sample_t samples [CHANNELS];
	sample_t medians [CHANNELS];
	sample_t med_q   [CHANNELS];

	// Handshake: results are loaded when the output register is free or emptying.
	assign load     = pend_q & (~out_valid_q | out_ready);
	assign in_ready = ~pend_q | load;
	assign accept   = in_valid & in_ready;
	assign push     = accept & (func == FUNC_PUSH);
	assign preload  = accept & (func == FUNC_PRELOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= push | (pend_q & ~load);
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Ring pointer: the slot the next push overwrites.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
		end else if (preload) begin
			oldest_q <= '0;
		end else if (push) begin
			oldest_q <= (oldest_q == LAST_TAG) ? '0 : oldest_q + tag_t'(1);
		end
	end

	assign samples[0] = accel_x;
	assign samples[1] = accel_y;
	assign samples[2] = accel_z;
	assign samples[3] = gyro_x;
	assign samples[4] = gyro_y;
	assign samples[5] = gyro_z;

	// One sorted cell row per channel.
	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
		mmf_chain u_chain (
			.clk     (clk),
			.arst_n  (arst_n),
			.push    (push),
			.preload (preload),
			.oldest  (oldest_q),
			.sample  (samples[ch]),
			.median  (medians[ch])
		);

		always_ff @(posedge clk) begin
			if (load) begin
				med_q[ch] <= medians[ch];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign med_accel_x = med_q[0];
	assign med_accel_y = med_q[1];
	assign med_accel_z = med_q[2];
	assign med_gyro_x  = med_q[3];
	assign med_gyro_y  = med_q[4];
	assign med_gyro_z  = med_q[5];

endmodule

@@ hw/rtl/mmf_checker.sv @@
// Port-level checks for the six-channel moving median filter, bound to the top
// level. Depends on mmf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mmf_checker import mmf_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input logic    func,
	input logic    out_valid,
	input logic    out_ready,
	input sample_t med_accel_x
);

	logic push_acc;
	logic out_stall;

	// Accepted push request, and a result that is offered but not taken.
	assign push_acc  = in_valid && in_ready && func == FUNC_PUSH;
	assign out_stall = out_valid && !out_ready;

	// A stalled result stays offered and unchanged.
	`MMF_ASSERT_NXT(a_out_hold, out_stall, out_valid)
	`MMF_ASSERT_NXT(a_out_stable, out_stall, $stable(med_accel_x))

	// A fresh result is checked against an earlier accepted push request.
	`MMF_ASSERT_IMP(a_out_from_push, $rose(out_valid), $past(push_acc, 2))

	// A push taken while the output is stalled blocks further requests until it drains.
	`MMF_ASSERT_NXT(a_push_backpressure, push_acc && out_stall, !in_ready || out_ready)

endmodule

bind six_channel_moving_median mmf_checker u_mmf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.func        (func),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.med_accel_x (med_accel_x)
);

@@ tb/sv/six_channel_moving_median_test.sv @@
// Self-checking testbench for the six-channel moving median filter.
// Depends on mmf_pkg and six_channel_moving_median; it predicts each channel's
// window median in software and compares every result the block returns.
module six_channel_moving_median_test import mmf_pkg::*;;

	localparam int CHANNELS     = 6;
	localparam int RANDOM_ITEMS = 1700;

	// One sample per channel: index 0 is accel_x, index 5 is gyro_z.
	typedef sample_t [CHANNELS-1:0] chan_vec_t;

	typedef struct packed {
		logic      func;
		chan_vec_t smp;
	} imu_req_t;

	// How the samples of a random sequence are spread.
	typedef enum int {FULL_RANGE, EXTREMES, NEAR_BASE, FEW_VALUES} spread_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	logic      func;
	sample_t   accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z;
	logic      out_valid;
	logic      out_ready;
	sample_t   med_accel_x, med_accel_y, med_accel_z, med_gyro_x, med_gyro_y, med_gyro_z;

	imu_req_t    pending_q[$];
	chan_vec_t   median_q[$];
	sample_t     hist [CHANNELS][WINDOW];
	int          slot_ptr;
	logic        in_fire;
	int unsigned in_gap, in_calm, rdy_left, rdy_calm;
	int unsigned n_push, n_preload, n_results, n_queued, errors;
	string       chan_name [CHANNELS] = '{"med_accel_x", "med_accel_y", "med_accel_z",
		"med_gyro_x", "med_gyro_y", "med_gyro_z"};

	six_channel_moving_median dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.med_accel_x(med_accel_x), .med_accel_y(med_accel_y), .med_accel_z(med_accel_z),
		.med_gyro_x(med_gyro_x), .med_gyro_y(med_gyro_y), .med_gyro_z(med_gyro_z)
	);

	always #2 clk = ~clk;

	// Gap length: mostly none or short, a few long, with occasional calm stretches.
	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 149) == 0)
			calm = $urandom_range(20, 80);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Median of one channel's window; an even window takes the floor average.
	function automatic sample_t window_median(int ch);
		sample_t srt [WINDOW];
		sample_t key;
		int      j;
		longint  pair_sum;
		for (int i = 0; i < WINDOW; i++)
			srt[i] = hist[ch][i];
		for (int i = 1; i < WINDOW; i++) begin
			key = srt[i];
			j = i - 1;
			while (j >= 0 && srt[j] > key) begin
				srt[j + 1] = srt[j];
				j--;
			end
			srt[j + 1] = key;
		end
		if (WINDOW % 2 == 0) begin
			pair_sum = longint'(srt[MID - 1]) + longint'(srt[MID]);
			return sample_t'(pair_sum >>> 1);
		end
		return srt[MID];
	endfunction

	// Applies one accepted request to the predicted windows; a push yields medians.
	function automatic bit apply_request(imu_req_t r, output chan_vec_t meds);
		meds = '0;
		if (r.func == FUNC_PRELOAD) begin
			for (int c = 0; c < CHANNELS; c++)
				for (int k = 0; k < WINDOW; k++)
					hist[c][k] = r.smp[c];
			slot_ptr = 0;
			return 1'b0;
		end
		for (int c = 0; c < CHANNELS; c++)
			hist[c][slot_ptr] = r.smp[c];
		slot_ptr = (slot_ptr + 1 >= WINDOW) ? 0 : slot_ptr + 1;
		for (int c = 0; c < CHANNELS; c++)
			meds[c] = window_median(c);
		return 1'b1;
	endfunction

	function automatic chan_vec_t rand_set(spread_t spread, chan_vec_t base);
		chan_vec_t s;
		for (int c = 0; c < CHANNELS; c++) begin
			case (spread)
				EXTREMES: begin
					case ($urandom_range(0, 4))
						0: s[c] = 16'sh7fff;
						1: s[c] = 16'sh8000;
						2: s[c] = 16'sh0000;
						3: s[c] = 16'shffff;
						default: s[c] = 16'sh0001;
					endcase
				end
				NEAR_BASE: s[c] = base[c] + sample_t'($urandom_range(0, 8)) - sample_t'(4);
				FEW_VALUES: s[c] = sample_t'($urandom_range(0, 3)) - sample_t'(1);
				default: s[c] = sample_t'($urandom);
			endcase
		end
		return s;
	endfunction

	function automatic chan_vec_t uniform_set(sample_t v);
		chan_vec_t s;
		for (int c = 0; c < CHANNELS; c++)
			s[c] = v;
		return s;
	endfunction

	task automatic queue_req(logic f, chan_vec_t s);
		imu_req_t r;
		r.func = f;
		r.smp = s;
		pending_q.push_back(r);
		n_queued++;
	endtask

	// Request driver: presents the next pending request after a random gap.
	always @(negedge clk) begin : drv
		imu_req_t nxt;
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					nxt = pending_q.pop_front();
					func    <= nxt.func;
					accel_x <= nxt.smp[0];
					accel_y <= nxt.smp[1];
					accel_z <= nxt.smp[2];
					gyro_x  <= nxt.smp[3];
					gyro_y  <= nxt.smp[4];
					gyro_z  <= nxt.smp[5];
					in_valid <= 1'b1;
					in_gap = pick_gap(in_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result side back-pressure: runs of ready broken by stalls of random length.
	always @(negedge clk) begin : rdy
		int unsigned g;
		if (arst_n) begin
			if (rdy_left > 0) begin
				rdy_left--;
			end else begin
				g = pick_gap(rdy_calm);
				if (g == 0) begin
					out_ready <= 1'b1;
					rdy_left = $urandom_range(0, 20);
				end else begin
					out_ready <= 1'b0;
					rdy_left = g - 1;
				end
			end
		end
	end

	// Monitor: checks each returned result, then predicts from accepted requests.
	always @(posedge clk or negedge arst_n) begin : mon
		chan_vec_t got, want, meds;
		imu_req_t  acc;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				got = {med_gyro_z, med_gyro_y, med_gyro_x, med_accel_z, med_accel_y, med_accel_x};
				if (median_q.size() == 0) begin
					$error("result returned with no request outstanding");
					errors++;
				end else begin
					want = median_q.pop_front();
					n_results++;
					for (int c = 0; c < CHANNELS; c++) begin
						if (got[c] !== want[c]) begin
							$error("%s: expected %0d, got %0d", chan_name[c],
								$signed(want[c]), $signed(got[c]));
							errors++;
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				acc.func = func;
				acc.smp = {gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x};
				if (apply_request(acc, meds)) begin
					median_q.push_back(meds);
					n_push++;
				end else begin
					n_preload++;
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		chan_vec_t mixed, base;
		spread_t   spread;
		int unsigned pick, run;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		func = FUNC_PUSH;
		{accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z} = '0;
		in_gap = 0; in_calm = 0; rdy_left = 0; rdy_calm = 0;
		n_push = 0; n_preload = 0; n_results = 0; n_queued = 0; errors = 0;
		slot_ptr = 0;
		for (int c = 0; c < CHANNELS; c++)
			for (int k = 0; k < WINDOW; k++)
				hist[c][k] = '0;
		mixed = {16'sh1234, 16'sh0001, 16'shffff, 16'sh0000, 16'sh8000, 16'sh7fff};

		// Pushes before any preload: the reset zeros still take part.
		queue_req(FUNC_PUSH, uniform_set(16'sh7fff));
		queue_req(FUNC_PUSH, uniform_set(16'sh8000));
		queue_req(FUNC_PUSH, mixed);
		queue_req(FUNC_PUSH, uniform_set(16'shffff));
		// Preload at each extreme and push the other; the second run goes until the median flips.
		queue_req(FUNC_PRELOAD, uniform_set(16'sh8000));
		queue_req(FUNC_PUSH, uniform_set(16'sh7fff));
		queue_req(FUNC_PRELOAD, uniform_set(16'sh7fff));
		repeat (MID + 1) queue_req(FUNC_PUSH, uniform_set(16'sh8000));
		// Mixed channels, back-to-back preloads and a preload that resets the slot.
		queue_req(FUNC_PRELOAD, mixed);
		queue_req(FUNC_PUSH, uniform_set(16'sh0000));
		queue_req(FUNC_PRELOAD, uniform_set(16'sh0001));
		queue_req(FUNC_PRELOAD, ~mixed);
		queue_req(FUNC_PUSH, mixed);
		queue_req(FUNC_PUSH, ~mixed);
		queue_req(FUNC_PUSH, uniform_set(16'sh5555));
		queue_req(FUNC_PUSH, uniform_set(16'shaaaa));

		// Random part: mostly a preload followed by a run of pushes, some lone requests.
		base = '0;
		while (n_queued < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			spread = spread_t'($urandom_range(0, 3));
			base = rand_set(FULL_RANGE, base);
			if (pick < 85) begin
				queue_req(FUNC_PRELOAD, rand_set(spread, base));
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 18);
				repeat (run) queue_req(FUNC_PUSH, rand_set(spread, base));
			end else if (pick < 93) begin
				queue_req(FUNC_PUSH, rand_set(FULL_RANGE, base));
			end else begin
				queue_req(FUNC_PRELOAD, rand_set(spread, base));
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || in_valid)
			@(posedge clk);
		while (median_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d push and %0d preload requests; %0d six-channel medians checked.",
			n_push, n_preload, n_results);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
